// ----- design/tswl_pkg.sv -----
package tswl_pkg;

	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [7:0] CHAR_ESC = 8'd27;

	// Cell 1 of every row holds the marker, so text starts in column 2.
	localparam logic [9:0] COL_FIRST   = 10'd2;
	localparam logic [9:0] COLS_RESET  = 10'd80;

	typedef struct packed {
		logic       restart;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic        row_is_continuation;
		logic        row_started;
		logic [2:0]  cells_written;
		logic [15:0] line_position;
		logic [15:0] line_number;
		logic [9:0]  next_column;
		logic [15:0] display_row;
	} result_t;

endpackage

// ----- design/tswl_in_stage.sv -----
module tswl_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tswl_pkg::item_t    in_item,
	input  logic               advance,
	output logic               valid_s1,
	output tswl_pkg::item_t    item_s1
);

	logic valid_s1_r;

	// The stage frees up in the same cycle that its beat moves on.
	assign in_ready = !valid_s1_r || advance;
	assign valid_s1 = valid_s1_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (in_ready) begin
			valid_s1_r <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- design/tswl_layout_core.sv -----
module tswl_layout_core #(
	parameter int TAB_STOP     = 4,
	parameter int COUNTER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tswl_pkg::item_t   item,
	input  logic [9:0]        screen_columns,
	output tswl_pkg::result_t result
);

	localparam int PW = $clog2(TAB_STOP);
	localparam int WW = 11;
	localparam logic [PW:0] TAB_W = (PW + 1)'(TAB_STOP);
	localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	logic [9:0]              col_q;
	logic [PW-1:0]           phase_q;
	logic [COUNTER_BITS-1:0] row_q;
	logic [COUNTER_BITS-1:0] line_q;
	logic [COUNTER_BITS-1:0] pos_q;

	logic [9:0]              col_e;
	logic [PW-1:0]           phase_e;
	logic [COUNTER_BITS-1:0] row_e;
	logic [COUNTER_BITS-1:0] line_e;
	logic [COUNTER_BITS-1:0] pos_e;

	logic                    is_nl;
	logic                    is_esc;
	logic                    is_tab;
	logic [WW-1:0]           space;
	logic [WW-1:0]           tab_gap;
	logic [WW-1:0]           want;
	logic [WW:0]             col_sum;
	logic                    wraps;
	logic [PW:0]             phase_inc;

	logic [9:0]              col_d;
	logic [PW-1:0]           phase_d;
	logic [COUNTER_BITS-1:0] row_d;
	logic [COUNTER_BITS-1:0] line_d;
	logic [COUNTER_BITS-1:0] pos_d;
	logic [2:0]              cells;
	logic                    started;

	logic [COUNTER_BITS+15:0] row_x;
	logic [COUNTER_BITS+15:0] line_x;
	logic [COUNTER_BITS+15:0] pos_x;

	always_comb begin
		if (item.restart) begin
			col_e   = tswl_pkg::COL_FIRST;
			phase_e = '0;
			row_e   = CNT_ONE;
			line_e  = '0;
			pos_e   = '0;
		end else begin
			col_e   = col_q;
			phase_e = phase_q;
			row_e   = row_q;
			line_e  = line_q;
			pos_e   = pos_q;
		end
	end

	assign is_nl  = (item.char_code == tswl_pkg::CHAR_LF) || (item.char_code == tswl_pkg::CHAR_CR);
	assign is_esc = (item.char_code == tswl_pkg::CHAR_ESC);
	assign is_tab = (item.char_code == tswl_pkg::CHAR_TAB);

	// The phase register holds (column - 2) mod TAB_STOP, so no divider is needed.
	assign space   = (screen_columns >= col_e) ?
	                 ({1'b0, screen_columns} - {1'b0, col_e} + WW'(1)) : '0;
	assign tab_gap = WW'(TAB_W - {1'b0, phase_e});

	always_comb begin
		if (is_tab) begin
			want = (tab_gap > space) ? space : tab_gap;
		end else begin
			want = WW'(1);
		end
	end

	assign col_sum   = {2'b00, col_e} + {1'b0, want};
	assign wraps     = !is_nl && !is_esc && (col_sum > {2'b00, screen_columns});
	assign phase_inc = {1'b0, phase_e} + (PW + 1)'(1);

	always_comb begin
		col_d   = col_e;
		phase_d = phase_e;
		row_d   = row_e;
		line_d  = line_e;
		pos_d   = pos_e;
		cells   = '0;
		started = 1'b0;
		if (is_nl) begin
			row_d   = (row_e == CNT_MAX) ? row_e : row_e + CNT_ONE;
			line_d  = (line_e == CNT_MAX) ? line_e : line_e + CNT_ONE;
			pos_d   = CNT_ONE;
			col_d   = tswl_pkg::COL_FIRST;
			phase_d = '0;
			started = 1'b1;
		end else if (!is_esc) begin
			pos_d = (pos_e == CNT_MAX) ? pos_e : pos_e + CNT_ONE;
			cells = want[2:0];
			if (wraps) begin
				row_d   = (row_e == CNT_MAX) ? row_e : row_e + CNT_ONE;
				col_d   = tswl_pkg::COL_FIRST;
				phase_d = '0;
				started = 1'b1;
			end else begin
				col_d = col_sum[9:0];
				// An unclipped tab always lands on a stop.
				if (is_tab || (phase_inc == TAB_W)) begin
					phase_d = '0;
				end else begin
					phase_d = phase_inc[PW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= tswl_pkg::COL_FIRST;
			phase_q <= '0;
			row_q   <= CNT_ONE;
			line_q  <= '0;
			pos_q   <= '0;
		end else if (step) begin
			col_q   <= col_d;
			phase_q <= phase_d;
			row_q   <= row_d;
			line_q  <= line_d;
			pos_q   <= pos_d;
		end
	end

	assign row_x  = {16'b0, row_d};
	assign line_x = {16'b0, line_d};
	assign pos_x  = {16'b0, pos_d};

	assign result.display_row         = row_x[15:0];
	assign result.next_column         = col_d;
	assign result.line_number         = line_x[15:0];
	assign result.line_position       = pos_x[15:0];
	assign result.cells_written       = cells;
	assign result.row_started         = started;
	assign result.row_is_continuation = wraps;

	a_col_floor: assert property (@(posedge clk) disable iff (!arst_n)
		col_q >= tswl_pkg::COL_FIRST)
		else $error("column fell below the first text column");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < TAB_W)
		else $error("tab phase out of range");

	a_nl_home: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_nl |=> (col_q == tswl_pkg::COL_FIRST) && (phase_q == '0))
		else $error("newline did not return to the first column");

	a_cont_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.row_is_continuation |-> result.row_started && !is_nl)
		else $error("continuation flagged without a wrapped row");

	a_esc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_esc && !item.restart |=> $stable(col_q) && $stable(row_q))
		else $error("escape byte moved the layout");

endmodule

// ----- design/text_soft_wrap_layout.sv -----
// A result goes out once its byte has passed the input and result registers.
// Throughput: one byte per cycle while m_tready is high. The layout update is a
// single pass of short adds and compares between the two registers.
// Reset clears all layout state (column 2, row 1, line and position 0)
// and sets screen_columns to 80; there is no clearing pass.
module text_soft_wrap_layout #(
	parameter int TAB_STOP     = 4,
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic [0:0]  s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	// display_row[15:0], next_column[25:16], line_number[41:26],
	// line_position[57:42], cells_written[60:58], row_started[61],
	// row_is_continuation[62], zero[63]
	output logic [63:0] m_tdata,
	input  logic        cfg_wen,
	input  logic [9:0]  cfg_wdata
);

	logic              advance;
	logic              valid_s1;
	logic              step;
	tswl_pkg::item_t   in_item;
	tswl_pkg::item_t   item_s1;
	tswl_pkg::result_t result;
	tswl_pkg::result_t result_q;
	logic              m_tvalid_q;
	logic [9:0]        screen_columns_q;

	assign in_item.restart   = s_tuser[0];
	assign in_item.char_code = s_tdata;

	// The whole pipe moves whenever the result register is empty or being drained.
	assign advance = !m_tvalid_q || m_tready;
	assign step    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_columns_q <= tswl_pkg::COLS_RESET;
		end else if (cfg_wen) begin
			screen_columns_q <= cfg_wdata;
		end
	end

	tswl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tswl_layout_core #(
		.TAB_STOP     (TAB_STOP),
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.item           (item_s1),
		.screen_columns (screen_columns_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, result_q};

endmodule

// ----- dv/text_soft_wrap_layout_checker.sv -----
module text_soft_wrap_layout_checker
	import tswl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        cfg_wen,
	input  logic [9:0]  cfg_wdata,
	output int          fails,
	output int          pending
);

	localparam int          TAB_STOP  = 4;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Private copy of the layout state and the width register.
	logic [9:0]  columns;
	logic [9:0]  column;
	logic [15:0] rows;
	logic [15:0] lines;
	logic [15:0] line_pos;
	logic        wrapped;

	result_t expected_layout[$];

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic void clear_layout();
		column   = COL_FIRST;
		rows     = 16'd1;
		wrapped  = 1'b0;
		lines    = 16'd0;
		line_pos = 16'd0;
	endfunction

	function automatic void enqueue_result(result_t r);
		expected_layout = {expected_layout, r};
	endfunction

	// Advances the layout by one byte and returns the result it should produce.
	function automatic result_t place_byte(item_t it);
		result_t r;
		int      col;
		int      want;
		int      off;
		int      space;
		logic    new_row;
		if (it.restart)
			clear_layout();
		col     = int'(column);
		new_row = 1'b0;
		want    = 0;
		if (it.char_code == CHAR_LF || it.char_code == CHAR_CR) begin
			rows     = sat_inc(rows);
			new_row  = 1'b1;
			wrapped  = 1'b0;
			lines    = sat_inc(lines);
			line_pos = 16'd1;
		end else if (it.char_code != CHAR_ESC) begin
			want = 1;
			if (it.char_code == CHAR_TAB) begin
				off   = (col >= 2) ? col - 2 : 0;
				space = (int'(columns) >= col) ? int'(columns) - col + 1 : 0;
				want  = TAB_STOP - (off % TAB_STOP);
				if (want > space)
					want = space;
			end
			col += want;
			if (col > int'(columns)) begin
				rows    = sat_inc(rows);
				new_row = 1'b1;
				wrapped = 1'b1;
			end
			line_pos = sat_inc(line_pos);
		end
		if (new_row)
			col = int'(COL_FIRST);
		column = col[9:0];
		r.display_row         = rows;
		r.next_column         = column;
		r.line_number         = lines;
		r.line_position       = line_pos;
		r.cells_written       = want[2:0];
		r.row_started         = new_row;
		r.row_is_continuation = new_row & wrapped;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			columns = COLS_RESET;
			clear_layout();
			expected_layout.delete();
			fails   = 0;
			pending <= 0;
		end else begin
			if (cfg_wen)
				columns = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[62:0]);
				check_field("pad", 16'd0, {15'd0, m_tdata[63]});
				if (expected_layout.size() == 0) begin
					$error("result beat arrived with no byte waiting for it");
					fails++;
				end else begin
					want = expected_layout.pop_front();
					check_field("display_row", want.display_row, got.display_row);
					check_field("next_column", 16'(want.next_column),
						16'(got.next_column));
					check_field("line_number", want.line_number, got.line_number);
					check_field("line_position", want.line_position, got.line_position);
					check_field("cells_written", 16'(want.cells_written),
						16'(got.cells_written));
					check_field("row_started", 16'(want.row_started),
						16'(got.row_started));
					check_field("row_is_continuation", 16'(want.row_is_continuation),
						16'(got.row_is_continuation));
				end
			end
			if (s_tvalid && s_tready)
				enqueue_result(place_byte(item_t'({s_tuser, s_tdata})));
			pending <= expected_layout.size();
		end
	end

endmodule

// ----- dv/text_soft_wrap_layout_test.sv -----
module text_soft_wrap_layout_test;
	import tswl_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_wen;
	logic [9:0]  cfg_wdata;

	int fails;
	int pending;
	int stall_cycles;
	bit idle_on;

	text_soft_wrap_layout dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	text_soft_wrap_layout_checker watcher (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver refuses beats at random while idling is enabled.
	always @(posedge clk) begin
		if (idle_on)
			m_tready <= ($urandom_range(99) >= 36);
		else
			m_tready <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("text_soft_wrap_layout_test: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic put_byte(input logic restart, input logic [7:0] code);
		while (idle_on && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= restart;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
	endtask

	// Holds the sender off until every byte has produced its result.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_columns(input logic [9:0] width);
		cfg_wen   <= 1'b1;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_code();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return CHAR_TAB;
		else if (roll < 17)
			return CHAR_LF;
		else if (roll < 21)
			return CHAR_CR;
		else if (roll < 26)
			return CHAR_ESC;
		return 8'($urandom_range(255));
	endfunction

	task automatic random_text(input int count);
		repeat (count)
			put_byte($urandom_range(99) < 2, pick_code());
	endtask

	initial begin
		logic [9:0] width;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		s_tuser   = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = 10'd0;
		idle_on   = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset width of 80: glyph extremes, tabs from several columns, line breaks.
		put_byte(1'b1, 8'h41);
		put_byte(1'b0, 8'h00);
		put_byte(1'b0, 8'hFF);
		put_byte(1'b0, CHAR_TAB);
		put_byte(1'b0, CHAR_TAB);
		put_byte(1'b0, CHAR_ESC);
		put_byte(1'b0, CHAR_LF);
		put_byte(1'b0, CHAR_TAB);
		put_byte(1'b0, CHAR_CR);
		put_byte(1'b0, 8'h80);
		put_byte(1'b0, 8'h7F);
		put_byte(1'b1, CHAR_LF);
		put_byte(1'b1, CHAR_ESC);
		repeat (8) put_byte(1'b0, 8'h2E);
		put_byte(1'b0, 8'h55);
		settle();

		// Width lowered below the current column: both glyph and tab wrap at once.
		set_columns(10'd10);
		put_byte(1'b0, CHAR_TAB);
		repeat (8) put_byte(1'b0, 8'h61);
		settle();
		set_columns(10'd5);
		put_byte(1'b0, 8'h62);
		settle();

		// Narrowest legal width, then the two widths below range.
		set_columns(10'd2);
		put_byte(1'b0, CHAR_TAB);
		put_byte(1'b0, 8'h63);
		put_byte(1'b0, CHAR_LF);
		settle();
		set_columns(10'd1);
		put_byte(1'b0, 8'h64);
		put_byte(1'b0, CHAR_TAB);
		settle();
		set_columns(10'd0);
		put_byte(1'b0, CHAR_TAB);
		put_byte(1'b0, 8'h65);
		random_text(20);
		settle();

		// Widest row: tabs and text far from the right edge.
		set_columns(10'd1023);
		put_byte(1'b1, 8'h66);
		repeat (3) put_byte(1'b0, CHAR_TAB);
		random_text(40);
		settle();

		// Random text over a spread of widths, mostly narrow ones.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: width = 10'd3;
				1: width = 10'($urandom_range(4, 12));
				2: width = 10'($urandom_range(13, 40));
				3: width = 10'($urandom_range(41, 1023));
				4: width = 10'($urandom_range(0, 1));
				5: width = 10'($urandom_range(2, 9));
				default: width = 10'($urandom_range(2, 1023));
			endcase
			idle_on = (phase != 2);
			set_columns(width);
			random_text(80);
			settle();
		end

		// A fresh text at the default width to finish.
		idle_on = 1'b1;
		set_columns(10'd80);
		put_byte(1'b1, 8'h69);
		random_text(30);

		settle();
		repeat (5) @(posedge clk);
		if (fails == 0)
			$display("text_soft_wrap_layout_test: done, clean");
		else
			$display("text_soft_wrap_layout_test: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/tswl_pkg.sv
design/tswl_in_stage.sv
design/tswl_layout_core.sv
design/text_soft_wrap_layout.sv
dv/text_soft_wrap_layout_checker.sv
dv/text_soft_wrap_layout_test.sv
